/* hw/rtl/cbr_pkg.sv */
// Shared constants and types for the conv/bias/ReLU core.
`default_nettype none
package cbr_pkg;
  localparam int IN_SIZE     = 16;
  localparam int IN_CHANNELS = 8;
  localparam int KERNEL      = 3;
  localparam int FILTERS     = 16;
  localparam int STRIDE      = 1;
  localparam int OUT_SIZE    = (IN_SIZE - KERNEL) / STRIDE + 1;
  localparam int IMG_WORDS   = IN_SIZE * IN_SIZE * IN_CHANNELS;
  localparam int WGT_WORDS   = FILTERS * IN_CHANNELS * KERNEL * KERNEL;
  localparam int TAPS        = IN_CHANNELS * KERNEL * KERNEL;
  localparam int IMG_AW      = $clog2(IMG_WORDS);
  localparam int WGT_AW      = $clog2(WGT_WORDS);
  localparam int BIAS_AW     = (FILTERS > 1) ? $clog2(FILTERS) : 1;
  localparam int CH_W        = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
  localparam int K_W         = (KERNEL > 1) ? $clog2(KERNEL) : 1;
  localparam int ACC_W       = 64;
  localparam int QDEPTH      = 2;

  typedef enum logic [1:0] {
    MODE_PIX  = 2'd0,
    MODE_WGT  = 2'd1,
    MODE_BIAS = 2'd2,
    MODE_COMP = 2'd3
  } mode_t;

  // one classified command handed from front to back
  typedef struct packed {
    mode_t       mode;
    logic [10:0] index;
    logic [31:0] value;
    logic [3:0]  filter_sel;
    logic [3:0]  out_row;
    logic [3:0]  out_col;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_BIAS,
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

/* hw/rtl/cbr_front.sv */
// Front end: accepts commands, drops out-of-range ones, queues the rest.
`default_nettype none
module cbr_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire cbr_pkg::cmd_t cmd_in,
  output logic               q_valid,
  output cbr_pkg::cmd_t      q_cmd,
  input  wire logic          q_pop
);
  localparam int PW = (cbr_pkg::QDEPTH > 1) ? $clog2(cbr_pkg::QDEPTH) : 1;

  cbr_pkg::cmd_t          fifo [cbr_pkg::QDEPTH];
  logic [PW-1:0]          wr_ptr;
  logic [PW-1:0]          rd_ptr;
  logic [PW:0]            count;
  logic                   keep;
  logic                   push;

  always_comb begin
    case (cmd_in.mode)
      cbr_pkg::MODE_PIX:  keep = 32'(cmd_in.index) < cbr_pkg::IMG_WORDS;
      cbr_pkg::MODE_WGT:  keep = 32'(cmd_in.index) < cbr_pkg::WGT_WORDS;
      cbr_pkg::MODE_BIAS: keep = 32'(cmd_in.index) < cbr_pkg::FILTERS;
      default:            keep = (32'(cmd_in.filter_sel) < cbr_pkg::FILTERS) &&
                                 (32'(cmd_in.out_row) < cbr_pkg::OUT_SIZE) &&
                                 (32'(cmd_in.out_col) < cbr_pkg::OUT_SIZE);
    endcase
  end

  assign busy    = (count == (PW+1)'(cbr_pkg::QDEPTH));
  assign push    = start && !busy && keep;
  assign q_valid = (count != '0);
  assign q_cmd   = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cmd_in;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == cbr_pkg::QDEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (32'(rd_ptr) == cbr_pkg::QDEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(q_pop);
    end
  end

`ifndef SYNTH
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    busy |=> count <= (PW+1)'(cbr_pkg::QDEPTH)) else $error("queue overflow");
  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (push && !q_pop) |=> count == $past(count) + 1'b1) else $error("count slip");
`endif
endmodule
`default_nettype wire

/* hw/rtl/cbr_back.sv */
// Back end: stores and the shared multiply-accumulate sequencer.
`default_nettype none
module cbr_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire cbr_pkg::cmd_t q_cmd,
  output logic               q_pop,
  output logic               done,
  output logic [30:0]        out_value
);
  logic [31:0] img_mem  [cbr_pkg::IMG_WORDS];
  logic [31:0] wgt_mem  [cbr_pkg::WGT_WORDS];
  logic [31:0] bias_mem [cbr_pkg::FILTERS];

  cbr_pkg::state_t state, state_next;
  cbr_pkg::cmd_t   cur;
  logic [cbr_pkg::CH_W-1:0] ch;
  logic [cbr_pkg::K_W-1:0]  ki, kj;
  logic                     last_tap;
  logic                     rd_v, prod_v;
  logic [31:0]              pix_q, wgt_q, bias_q;
  logic signed [63:0]       prod;
  logic signed [cbr_pkg::ACC_W-1:0] acc;
  logic [30:0]              result;
  logic [31:0]              pa, wa;
  logic                     take_wr, take_comp, issue;

  assign take_wr   = (state == cbr_pkg::ST_IDLE) && q_valid &&
                     (q_cmd.mode != cbr_pkg::MODE_COMP);
  assign take_comp = (state == cbr_pkg::ST_IDLE) && q_valid &&
                     (q_cmd.mode == cbr_pkg::MODE_COMP);
  assign q_pop     = take_wr || take_comp;
  assign issue     = (state == cbr_pkg::ST_RUN);
  assign last_tap  = (32'(ch) == cbr_pkg::IN_CHANNELS - 1) &&
                     (32'(ki) == cbr_pkg::KERNEL - 1) && (32'(kj) == cbr_pkg::KERNEL - 1);

  // address generation: row/col offsets are small, products are of constants
  always_comb begin
    pa = (32'(ch) * cbr_pkg::IN_SIZE + 32'(cur.out_row) * cbr_pkg::STRIDE + 32'(ki))
         * cbr_pkg::IN_SIZE + 32'(cur.out_col) * cbr_pkg::STRIDE + 32'(kj);
    wa = ((32'(cur.filter_sel) * cbr_pkg::IN_CHANNELS + 32'(ch)) * cbr_pkg::KERNEL
          + 32'(ki)) * cbr_pkg::KERNEL + 32'(kj);
  end

  always_comb begin
    state_next = state;
    case (state)
      cbr_pkg::ST_IDLE:  if (take_comp) state_next = cbr_pkg::ST_RUN;
      cbr_pkg::ST_RUN:   if (last_tap) state_next = cbr_pkg::ST_DRAIN;
      cbr_pkg::ST_DRAIN: if (!rd_v && !prod_v) state_next = cbr_pkg::ST_BIAS;
      cbr_pkg::ST_BIAS:  state_next = cbr_pkg::ST_DONE;
      cbr_pkg::ST_DONE:  state_next = cbr_pkg::ST_IDLE;
      default:           state_next = cbr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    done = (state == cbr_pkg::ST_DONE);
  end

  // ReLU and saturation on the final sum
  always_comb begin
    if (acc[cbr_pkg::ACC_W-1] || acc == '0) begin
      result = '0;
    end else if (acc > cbr_pkg::ACC_W'(32'h7FFF_FFFF)) begin
      result = 31'h7FFF_FFFF;
    end else begin
      result = acc[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (take_wr) begin
      case (q_cmd.mode)
        cbr_pkg::MODE_PIX:  img_mem[q_cmd.index[cbr_pkg::IMG_AW-1:0]] <= q_cmd.value;
        cbr_pkg::MODE_WGT:  wgt_mem[q_cmd.index[cbr_pkg::WGT_AW-1:0]] <= q_cmd.value;
        cbr_pkg::MODE_BIAS: bias_mem[q_cmd.index[cbr_pkg::BIAS_AW-1:0]] <= q_cmd.value;
        default: ;
      endcase
    end
    if (take_comp) cur <= q_cmd;
    pix_q  <= img_mem[pa[cbr_pkg::IMG_AW-1:0]];
    wgt_q  <= wgt_mem[wa[cbr_pkg::WGT_AW-1:0]];
    bias_q <= bias_mem[cur.filter_sel[cbr_pkg::BIAS_AW-1:0]];
    prod   <= $signed(wgt_q) * $signed(pix_q);
    if (state == cbr_pkg::ST_DONE) out_value <= result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= cbr_pkg::ST_IDLE;
      rd_v   <= 1'b0;
      prod_v <= 1'b0;
      ch <= '0; ki <= '0; kj <= '0;
      acc    <= '0;
    end else begin
      state  <= state_next;
      rd_v   <= issue;
      prod_v <= rd_v;
      if (take_comp) begin
        acc <= '0;
        ch <= '0; ki <= '0; kj <= '0;
      end else if (issue) begin
        if (32'(kj) == cbr_pkg::KERNEL - 1) begin
          kj <= '0;
          if (32'(ki) == cbr_pkg::KERNEL - 1) begin
            ki <= '0;
            ch <= (32'(ch) == cbr_pkg::IN_CHANNELS - 1) ? '0 : ch + 1'b1;
          end else begin
            ki <= ki + 1'b1;
          end
        end else begin
          kj <= kj + 1'b1;
        end
      end
      if (prod_v) begin
        acc <= acc + (prod >>> 16);
      end else if (state == cbr_pkg::ST_BIAS) begin
        acc <= acc + cbr_pkg::ACC_W'($signed(bias_q));
      end
    end
  end

`ifndef SYNTH
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == cbr_pkg::ST_IDLE) else $error("pop while busy");
  a_done_after_bias: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == cbr_pkg::ST_BIAS) else $error("done out of order");
  a_no_mac_idle: assert property (@(posedge clk) disable iff (rst)
    state == cbr_pkg::ST_IDLE |-> !rd_v && !prod_v) else $error("stray mac");
`endif
endmodule
`default_nettype wire

/* hw/rtl/conv_bias_relu_layer_core.sv */
// Top level of the conv/bias/ReLU core: front queue plus MAC back end.
// With the back end idle, an accepted compute passes the queue, then issues one MAC per
//   tap through the shared multiplier, drains, adds the bias and registers out_value before done rises.
// The back end pops no new command until a compute is done; writes are taken from idle.
// The two-entry command queue lets start pulse while a compute is running.
// rst is synchronous, active high; it clears control only, stores hold garbage.
// The result strobe done has no back pressure: out_value is valid that one cycle.
`default_nettype none
module conv_bias_relu_layer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  mode,
  input  wire logic [10:0] index,
  input  wire logic signed [31:0] value,
  input  wire logic [3:0]  filter_sel,
  input  wire logic [3:0]  out_row,
  input  wire logic [3:0]  out_col,
  output logic             done,
  output logic [30:0]      out_value
);
  cbr_pkg::cmd_t cmd_in;
  cbr_pkg::cmd_t q_cmd;
  logic          q_valid;
  logic          q_pop;
  logic          done_r;

  // pack the command transfer
  always_comb begin
    cmd_in.mode       = cbr_pkg::mode_t'(mode);
    cmd_in.index      = index;
    cmd_in.value      = value;
    cmd_in.filter_sel = filter_sel;
    cmd_in.out_row    = out_row;
    cmd_in.out_col    = out_col;
  end

  cbr_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd_in(cmd_in),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  cbr_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .done(done_r), .out_value(out_value)
  );

  // out_value is registered on the back end's done cycle; the strobe is registered and rises in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= done_r;
    end
  end

`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held two cycles");
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(done_r)) else $error("strobe without compute");
  a_busy_needs_q: assert property (@(posedge clk) disable iff (rst)
    busy |-> q_valid) else $error("busy with empty queue");
`endif
endmodule
`default_nettype wire

/* verif/conv_bias_relu_layer_core_tb.sv */
// Self-checking testbench for the conv/bias/ReLU core: directed table, then random traffic.
`default_nettype none
module conv_bias_relu_layer_core_tb;
  import cbr_pkg::*;

  // computes stay inside a footprint that is fully written before any compute
  localparam int N_FILT_USED = 2;
  localparam int N_ROWS_USED = 2;
  localparam int PIX_ROWS    = (N_ROWS_USED - 1) * STRIDE + KERNEL;
  localparam int WGT_USED    = N_FILT_USED * IN_CHANNELS * KERNEL * KERNEL;

  // DUT hookup
  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  mode;
  logic [10:0] index;
  logic signed [31:0] value;
  logic [3:0]  filter_sel;
  logic [3:0]  out_row;
  logic [3:0]  out_col;
  logic        done;
  logic [30:0] out_value;

  conv_bias_relu_layer_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode(mode), .index(index), .value(value),
    .filter_sel(filter_sel), .out_row(out_row), .out_col(out_col),
    .done(done), .out_value(out_value)
  );

  // one command plus, for directed rows, an optional typed-in answer
  typedef struct {
    mode_t       md;
    logic [10:0] idx;
    logic [31:0] val;
    logic [3:0]  fsel;
    logic [3:0]  orow;
    logic [3:0]  ocol;
    bit          has_fixed;
    logic [30:0] fixed_val;
  } cmd_row_t;

  // predictor copy of the stores
  logic [31:0] pix_mem [IMG_WORDS];
  logic [31:0] wgt_mem [WGT_WORDS];
  logic [31:0] bias_mem [FILTERS];

  logic [30:0] pending_outs [$];
  int          err_count;
  bit          stim_done;
  cmd_row_t    dir_tab [$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // safety net: a time-out many times over the worst case for about 1500 items
  initial begin
    #4000000;
    $display("** conv_bias_relu_layer_core: FAILED **");
    $finish;
  end

  // Q16.16 product floored back to Q16.16; arithmetic shift does the flooring
  function automatic logic signed [63:0] qprod(logic [31:0] a, logic [31:0] b);
    logic signed [63:0] p;
    p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
    return p >>> 16;
  endfunction

  // applies one command to the store copy; returns 1 and the answer for a valid compute
  function automatic bit conv_predict(cmd_row_t c, output logic [30:0] res);
    logic signed [63:0] acc;
    int pa, wa;
    res = '0;
    case (c.md)
      MODE_PIX: begin
        if (c.idx < IMG_WORDS) pix_mem[c.idx] = c.val;
        return 0;
      end
      MODE_WGT: begin
        if (c.idx < WGT_WORDS) wgt_mem[c.idx] = c.val;
        return 0;
      end
      MODE_BIAS: begin
        if (c.idx < FILTERS) bias_mem[c.idx[3:0]] = c.val;
        return 0;
      end
      default: begin
        if (c.fsel >= FILTERS || c.orow >= OUT_SIZE || c.ocol >= OUT_SIZE) return 0;
        acc = 0;
        for (int ch = 0; ch < IN_CHANNELS; ch++)
          for (int i = 0; i < KERNEL; i++)
            for (int j = 0; j < KERNEL; j++) begin
              pa = (ch * IN_SIZE + c.orow * STRIDE + i) * IN_SIZE + c.ocol * STRIDE + j;
              wa = ((c.fsel * IN_CHANNELS + ch) * KERNEL + i) * KERNEL + j;
              acc += qprod(wgt_mem[wa], pix_mem[pa]);
            end
        acc += $signed({{32{bias_mem[c.fsel][31]}}, bias_mem[c.fsel]});
        if (acc <= 0) res = '0;
        else if (acc > 64'sh7FFF_FFFF) res = 31'h7FFF_FFFF;
        else res = acc[30:0];
        return 1;
      end
    endcase
  endfunction

  // transfer one command: hold start until an edge with busy low
  task automatic send_cmd(cmd_row_t c);
    logic [30:0] r;
    bit          has;
    int          gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    mode       <= c.md;
    index      <= c.idx;
    value      <= c.val;
    filter_sel <= c.fsel;
    out_row    <= c.orow;
    out_col    <= c.ocol;
    @(posedge clk);
    while (busy) @(posedge clk);
    has = conv_predict(c, r);
    if (has) begin
      if (c.has_fixed && r !== c.fixed_val) begin
        $error("out_value: table expects %h, predictor gives %h", c.fixed_val, r);
        err_count++;
      end
      pending_outs.push_back(c.has_fixed ? c.fixed_val : r);
    end
  endtask

  // drop start and wait until every outstanding result is back
  task automatic drain_outs();
    start <= 1'b0;
    while (pending_outs.size() != 0) @(posedge clk);
  endtask

  function automatic cmd_row_t mk(mode_t m, int idx, logic [31:0] v,
                                  int f = 0, int r = 0, int cc = 0,
                                  bit fx = 0, logic [30:0] fv = '0);
    cmd_row_t c;
    c.md = m; c.idx = 11'(idx); c.val = v; c.fsel = 4'(f); c.orow = 4'(r);
    c.ocol = 4'(cc);
    c.has_fixed = fx; c.fixed_val = fv;
    return c;
  endfunction

  // result checker: done has no back pressure, so sample every edge
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_outs.size() == 0) begin
        $error("out_value: unexpected result %h", out_value);
        err_count++;
      end else begin
        logic [30:0] exp_v;
        exp_v = pending_outs.pop_front();
        if (out_value !== exp_v) begin
          $error("out_value: expected %h, actual %h", exp_v, out_value);
          err_count++;
        end
      end
    end
  end

  // fill the footprint: random pixels in the used rows, zero weights and biases
  task automatic fill_all();
    logic [31:0] v;
    for (int ch = 0; ch < IN_CHANNELS; ch++)
      for (int r = 0; r < PIX_ROWS; r++)
        for (int q = 0; q < IN_SIZE; q++) begin
          v = $urandom_range(0, 32'h3_0000) - 32'h1_8000;
          send_cmd(mk(MODE_PIX, (ch * IN_SIZE + r) * IN_SIZE + q, v));
        end
    for (int i = 0; i < WGT_USED; i++) begin
      send_cmd(mk(MODE_WGT, i, 32'h0));
    end
    for (int i = 0; i < FILTERS; i++) begin
      send_cmd(mk(MODE_BIAS, i, 32'h0));
    end
  endtask

  // a pixel address inside the footprint
  function automatic int foot_pix();
    return ($urandom_range(0, IN_CHANNELS - 1) * IN_SIZE + $urandom_range(0, PIX_ROWS - 1))
           * IN_SIZE + $urandom_range(0, IN_SIZE - 1);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(0, 32'h4_0000) - 32'h2_0000;
    endcase
  endfunction

  initial begin
    cmd_row_t c;
    int       n_done;
    err_count = 0;
    stim_done = 0;
    rst = 1'b1; start = 1'b0; mode = '0; index = '0; value = '0;
    filter_sel = '0; out_row = '0; out_col = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero weights: result is bias alone
    fill_all();
    dir_tab.push_back(mk(MODE_COMP, 0, 0, 0, 0, 0, 1, 31'h0));
    dir_tab.push_back(mk(MODE_BIAS, 1, 32'h0001_0000));
    dir_tab.push_back(mk(MODE_COMP, 0, 0, 1, 1, 13, 1, 31'h1_0000));
    dir_tab.push_back(mk(MODE_BIAS, 1, 32'h7FFF_FFFF));
    dir_tab.push_back(mk(MODE_COMP, 0, 0, 1, 0, 13, 1, 31'h7FFF_FFFF));
    dir_tab.push_back(mk(MODE_BIAS, 1, 32'h8000_0000));          // negative clamps to zero
    dir_tab.push_back(mk(MODE_COMP, 0, 0, 1, 1, 0, 1, 31'h0));
    // top pixel address, then out-of-range writes that are dropped
    dir_tab.push_back(mk(MODE_PIX, 2047, 32'hFFFF_FFFF));
    dir_tab.push_back(mk(MODE_WGT, 2047, 32'hFFFF_FFFF));
    dir_tab.push_back(mk(MODE_WGT, WGT_WORDS, 32'h1234_5678));
    dir_tab.push_back(mk(MODE_BIAS, 2047, 32'h7FFF_FFFF));
    dir_tab.push_back(mk(MODE_BIAS, FILTERS, 32'h7FFF_FFFF));
    dir_tab.push_back(mk(MODE_COMP, 0, 0, 0, 0, 0, 1, 31'h0));
    // out-of-range computes give nothing
    dir_tab.push_back(mk(MODE_COMP, 2047, 32'hFFFF_FFFF, 15, 14, 0));
    dir_tab.push_back(mk(MODE_COMP, 0, 0, 0, 0, 15));
    dir_tab.push_back(mk(MODE_COMP, 0, 0, 15, 15, 15));
    // max times max saturates; max times min clamps to zero; min times min saturates too
    dir_tab.push_back(mk(MODE_WGT, 0, 32'h7FFF_FFFF));
    dir_tab.push_back(mk(MODE_PIX, 0, 32'h7FFF_FFFF));
    dir_tab.push_back(mk(MODE_COMP, 0, 0, 0, 0, 0, 1, 31'h7FFF_FFFF));
    dir_tab.push_back(mk(MODE_PIX, 0, 32'h8000_0000));
    dir_tab.push_back(mk(MODE_COMP, 0, 0, 0, 0, 0, 1, 31'h0));
    dir_tab.push_back(mk(MODE_WGT, 0, 32'h8000_0000));
    dir_tab.push_back(mk(MODE_COMP, 0, 0, 0, 0, 0, 1, 31'h7FFF_FFFF));
    // small negative product floors toward minus infinity
    dir_tab.push_back(mk(MODE_WGT, 0, 32'hFFFF_FFFF));
    dir_tab.push_back(mk(MODE_PIX, 0, 32'h0000_0001));
    dir_tab.push_back(mk(MODE_COMP, 0, 0, 0, 0, 0));
    foreach (dir_tab[i]) send_cmd(dir_tab[i]);

    // pause until every outstanding result is back
    drain_outs();

    // random rewrites mixed with computes inside the footprint and out-of-range computes
    n_done = 0;
    while (n_done < 800) begin
      case ($urandom_range(0, 9))
        0: c = mk(MODE_PIX,
                  ($urandom_range(0, 1) != 0) ? foot_pix() : $urandom_range(0, 2047),
                  rand_word());
        1: c = mk(MODE_WGT,
                  ($urandom_range(0, 1) != 0) ? $urandom_range(0, WGT_USED - 1)
                                              : $urandom_range(0, 2047),
                  rand_word());
        2: c = mk(MODE_BIAS,
                  ($urandom_range(0, 1) != 0) ? $urandom_range(0, N_FILT_USED - 1)
                                              : $urandom_range(0, 2047),
                  $urandom);
        3: c = ($urandom_range(0, 1) != 0) ?
               mk(MODE_COMP, $urandom_range(0, 2047), $urandom, $urandom_range(0, 15),
                  $urandom_range(OUT_SIZE, 15), $urandom_range(0, 15)) :
               mk(MODE_COMP, $urandom_range(0, 2047), $urandom, $urandom_range(0, 15),
                  $urandom_range(0, 15), $urandom_range(OUT_SIZE, 15));
        default: c = mk(MODE_COMP, $urandom_range(0, 2047), $urandom,
                        $urandom_range(0, N_FILT_USED - 1),
                        $urandom_range(0, N_ROWS_USED - 1),
                        $urandom_range(0, OUT_SIZE - 1));
      endcase
      send_cmd(c);
      n_done++;
      if (n_done == 400)
        drain_outs();
    end

    drain_outs();
    repeat (100) @(posedge clk);
    if (err_count == 0 && pending_outs.size() == 0)
      $display("** conv_bias_relu_layer_core: PASSED **");
    else
      $display("** conv_bias_relu_layer_core: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/cbr_pkg.sv
hw/rtl/cbr_front.sv
hw/rtl/cbr_back.sv
hw/rtl/conv_bias_relu_layer_core.sv
verif/conv_bias_relu_layer_core_tb.sv
